FILE: hdl/wpr_pkg.sv
// wpr_pkg: shared types and constants for the windowed peak reselect block
// no dependencies; imported by wpr_front, wpr_back and windowed_peak_reselect_top

package wpr_pkg;

    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 10;
    localparam int INDEX_W  = 9;
    localparam int WINDOW_W = 17;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 17'd7200;

    // command codes on the input channel
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // decoded operations handed from front to back
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_EVAL   = 2'd1,
        OP_READ   = 2'd2,
        OP_SKIP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANCHOR,
        ST_SCAN,
        ST_PICK,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [LEVEL_W-1:0] level;
        logic               peak;
    } sample_t;

    typedef struct packed {
        op_t     op;
        sample_t smp;
    } job_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               mark_value;
        logic               status;
    } result_t;

endpackage

FILE: hdl/wpr_front.sv
// wpr_front: accepts commands, keeps the loaded count, classifies each command
// depends on wpr_pkg; feeds wpr_fifo

module wpr_front #(
    parameter int SERIES_DEPTH = 512,
    localparam int IDX_W = $clog2(SERIES_DEPTH),
    localparam int CNT_W = $clog2(SERIES_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [1:0]                   command,
    input  logic [wpr_pkg::TIME_W-1:0]   sample_time,
    input  logic [wpr_pkg::LEVEL_W-1:0]  glucose_level,
    input  logic                         peak_flag,
    input  logic [wpr_pkg::INDEX_W-1:0]  sample_index,
    input  logic                         q_full,
    output logic                         q_push,
    output wpr_pkg::job_t                q_job,
    output logic [IDX_W-1:0]             q_addr,
    output logic [CNT_W-1:0]             q_cnt
);
    import wpr_pkg::*;

    localparam int CW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;
    logic             loaded;

    assign item_ready = !q_full;
    assign accept     = item_valid && !q_full;
    assign loaded     = CW'(sample_index) < CW'(count_reg);

    always_comb
    begin
        count_next    = count_reg;
        q_push        = 1'b0;
        q_job.op      = OP_SKIP;
        q_job.smp     = '{stamp: sample_time, level: glucose_level, peak: peak_flag};
        q_addr        = IDX_W'(sample_index);
        q_cnt         = count_reg;
        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_START:
                begin
                    count_next = '0;
                end
                CMD_APPEND:
                begin
                    // full store drops the sample
                    if (count_reg != CNT_W'(SERIES_DEPTH))
                    begin
                        q_push     = 1'b1;
                        q_job.op   = OP_APPEND;
                        q_addr     = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_EVAL:
                begin
                    q_push   = 1'b1;
                    q_job.op = loaded ? OP_EVAL : OP_SKIP;
                end
                CMD_READ:
                begin
                    q_push   = 1'b1;
                    q_job.op = loaded ? OP_READ : OP_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/wpr_fifo.sv
// wpr_fifo: two-entry queue between the front and the back
// no dependencies

module wpr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/wpr_back.sv
// wpr_back: sample and mark stores, window scan sequencer, result register
// depends on wpr_pkg; drained from wpr_fifo

module wpr_back #(
    parameter int SERIES_DEPTH = 512,
    localparam int IDX_W = $clog2(SERIES_DEPTH),
    localparam int CNT_W = $clog2(SERIES_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  wpr_pkg::job_t                 q_job,
    input  logic [IDX_W-1:0]              q_addr,
    input  logic [CNT_W-1:0]              q_cnt,
    output logic                          q_pop,
    input  logic [wpr_pkg::WINDOW_W-1:0]  window,
    output logic                          result_valid,
    input  logic                          result_ready,
    output wpr_pkg::result_t              res
);
    import wpr_pkg::*;

    sample_t sample_mem [SERIES_DEPTH];
    logic    mark_mem   [SERIES_DEPTH];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   anchor_reg, anchor_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  lo_reg, lo_next;
    logic [TIME_W:0]    hi_reg, hi_next;
    logic [LEVEL_W-1:0] anchor_lvl_reg, anchor_lvl_next;
    logic [LEVEL_W-1:0] best_lvl_reg, best_lvl_next;
    logic               found_reg, found_next;
    result_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               smp_we;
    logic [IDX_W-1:0]   smp_raddr;
    sample_t            smp_rd_reg;
    logic               mark_we, mark_wdata;
    logic [IDX_W-1:0]   mark_waddr;
    logic               mark_rd_reg;

    logic               hit, last, better;
    logic [IDX_W-1:0]   chosen;

    assign result_valid = res_valid_reg;
    assign res          = res_reg;

    assign hit    = smp_rd_reg.peak && (smp_rd_reg.stamp >= lo_reg)
                    && ({1'b0, smp_rd_reg.stamp} <= hi_reg);
    assign better = !found_reg || (smp_rd_reg.level > best_lvl_reg);
    assign last   = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == cnt_reg;
    assign chosen = (!found_reg || (anchor_lvl_reg > best_lvl_reg)) ? anchor_reg
                                                                    : best_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        anchor_next     = anchor_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        anchor_lvl_next = anchor_lvl_reg;
        best_lvl_next   = best_lvl_reg;
        found_next      = found_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        q_pop           = 1'b0;
        smp_we          = 1'b0;
        smp_raddr       = scan_idx_reg + IDX_W'(1);
        mark_we         = 1'b0;
        mark_wdata      = 1'b0;
        mark_waddr      = q_addr;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_job.op)
                        OP_APPEND:
                        begin
                            // a fresh entry starts unmarked
                            q_pop   = 1'b1;
                            smp_we  = 1'b1;
                            mark_we = 1'b1;
                        end
                        OP_SKIP:
                        begin
                            if (!res_valid_reg)
                            begin
                                q_pop          = 1'b1;
                                res_next       = '{chosen_index: '0, mark_value: 1'b0,
                                                   status: 1'b1};
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (!res_valid_reg)
                            begin
                                q_pop      = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        OP_EVAL:
                        begin
                            if (!res_valid_reg)
                            begin
                                q_pop       = 1'b1;
                                anchor_next = q_addr;
                                cnt_next    = q_cnt;
                                smp_raddr   = q_addr;
                                state_next  = ST_ANCHOR;
                            end
                        end
                    endcase
                end
            end
            ST_ANCHOR:
            begin
                lo_next         = smp_rd_reg.stamp;
                hi_next         = {1'b0, smp_rd_reg.stamp} + (TIME_W + 1)'(window);
                anchor_lvl_next = smp_rd_reg.level;
                found_next      = 1'b0;
                scan_idx_next   = '0;
                smp_raddr       = '0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit && better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = scan_idx_reg;
                    best_lvl_next = smp_rd_reg.level;
                end
                if (last)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_PICK:
            begin
                mark_we        = 1'b1;
                mark_wdata     = 1'b1;
                mark_waddr     = chosen;
                res_next       = '{chosen_index: INDEX_W'(chosen), mark_value: 1'b1,
                                   status: 1'b0};
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ:
            begin
                res_next       = '{chosen_index: '0, mark_value: mark_rd_reg, status: 1'b0};
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        anchor_reg     <= anchor_next;
        scan_idx_reg   <= scan_idx_next;
        best_idx_reg   <= best_idx_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        anchor_lvl_reg <= anchor_lvl_next;
        best_lvl_reg   <= best_lvl_next;
        found_reg      <= found_next;
        res_reg        <= res_next;
    end

    // sample store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            sample_mem[q_addr] <= q_job.smp;
        end
        smp_rd_reg <= sample_mem[smp_raddr];
    end

    // mark store, read address always follows the queue head
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[q_addr];
    end

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_idx_reg) < cnt_reg))
        else $error("scan index beyond loaded count");

    a_pick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |=> (res_valid_reg && res_reg.mark_value && !res_reg.status))
        else $error("evaluate did not post a marked result");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("queue popped while sequencer busy");

    a_pick_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK || state_reg == ST_READ) |-> !res_valid_reg)
        else $error("result register overwritten");

endmodule

FILE: hdl/windowed_peak_reselect_top.sv
// from the accepting edge to result valid, result register free: a skip posts from ST_IDLE,
// a read via ST_READ, an evaluate via ST_ANCHOR, ST_SCAN and ST_PICK. throughput: one append
// per cycle unless the back stalls; a read holds the back in ST_READ, an evaluate for its
// one-entry-per-cycle scan of the single sample store read port
// reset: asynchronous, active low; clears the loaded count, the queue and the result valid
// flag and sets window_length to 7200; the stores need no clearing pass

module windowed_peak_reselect_top #(
    parameter int SERIES_DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          window_length_we,
    input  logic [wpr_pkg::WINDOW_W-1:0]  window_length_data,
    // command channel
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    command,
    input  logic [wpr_pkg::TIME_W-1:0]    sample_time,
    input  logic [wpr_pkg::LEVEL_W-1:0]   glucose_level,
    input  logic                          peak_flag,
    input  logic [wpr_pkg::INDEX_W-1:0]   sample_index,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [wpr_pkg::INDEX_W-1:0]   chosen_index,
    output logic                          mark_value,
    output logic                          status
);
    import wpr_pkg::*;

    localparam int IDX_W = $clog2(SERIES_DEPTH);
    localparam int CNT_W = $clog2(SERIES_DEPTH + 1);
    localparam int Q_W   = $bits(job_t) + IDX_W + CNT_W;

    // window register, to be written only while the block is quiet; the block does not enforce it
    logic [WINDOW_W-1:0] window_reg, window_next;

    // front to queue
    logic             f_push;
    job_t             f_job;
    logic [IDX_W-1:0] f_addr;
    logic [CNT_W-1:0] f_cnt;
    logic             q_full;

    // queue to back
    logic [Q_W-1:0]   q_data;
    logic             q_valid;
    logic             q_pop;
    job_t             b_job;
    logic [IDX_W-1:0] b_addr;
    logic [CNT_W-1:0] b_cnt;

    result_t          res;

    assign window_next = window_length_we ? window_length_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    // front: owns loaded_count so every command is classified in order;
    // start and dropped appends finish here and never reach the queue
    wpr_front #(
        .SERIES_DEPTH (SERIES_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .sample_time   (sample_time),
        .glucose_level (glucose_level),
        .peak_flag     (peak_flag),
        .sample_index  (sample_index),
        .q_full        (q_full),
        .q_push        (f_push),
        .q_job         (f_job),
        .q_addr        (f_addr),
        .q_cnt         (f_cnt)
    );

    // decoded job, store address and a snapshot of the count for the scan bound
    wpr_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_job, f_addr, f_cnt}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    assign b_job  = job_t'(q_data[Q_W-1 -: $bits(job_t)]);
    assign b_addr = q_data[CNT_W +: IDX_W];
    assign b_cnt  = q_data[CNT_W-1:0];

    // back: stores, scan sequencer and the result register that decouples
    // the result channel from the queue
    wpr_back #(
        .SERIES_DEPTH (SERIES_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (b_job),
        .q_addr       (b_addr),
        .q_cnt        (b_cnt),
        .q_pop        (q_pop),
        .window       (window_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .res          (res)
    );

    assign chosen_index = res.chosen_index;
    assign mark_value   = res.mark_value;
    assign status       = res.status;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for windowed_peak_reselect_top, directed table then random series
// depends on wpr_pkg and windowed_peak_reselect_top from hdl

module tb;
    import wpr_pkg::*;

    localparam int SERIES_DEPTH  = 512;
    // an evaluate scans the whole series, so let that long pass before a window write
    localparam int SETTLE_CYCLES = SERIES_DEPTH + 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 3000;
    // about 950 transfers, each worst case a full scan plus sender and receiver stalls,
    // plus the settle waits and the hold-off, then taken a few times over
    localparam int CYCLE_LIMIT   = 3000000;

    localparam result_t SKIP_RES  = '{chosen_index: '0, mark_value: 1'b0, status: 1'b1};
    localparam result_t CLEAR_RES = '{chosen_index: '0, mark_value: 1'b0, status: 1'b0};

    // one row of the directed table; typed rows carry their own expected result
    typedef struct {
        cmd_t               op;
        logic [TIME_W-1:0]  stamp;
        logic [LEVEL_W-1:0] level;
        logic               peak;
        logic [INDEX_W-1:0] index;
        bit                 typed;
        result_t            res;
    } step_row_t;

    logic                clk                = 1'b0;
    logic                rst_n              = 1'b0;
    logic                window_length_we   = 1'b0;
    logic [WINDOW_W-1:0] window_length_data = '0;
    logic                item_valid         = 1'b0;
    logic                item_ready;
    logic [1:0]          command            = CMD_START;
    logic [TIME_W-1:0]   sample_time        = '0;
    logic [LEVEL_W-1:0]  glucose_level      = '0;
    logic                peak_flag          = 1'b0;
    logic [INDEX_W-1:0]  sample_index       = '0;
    logic                result_valid;
    logic                result_ready       = 1'b0;
    logic [INDEX_W-1:0]  chosen_index;
    logic                mark_value;
    logic                status;

    // shadow copy of the block state
    logic [TIME_W-1:0]   shadow_time  [SERIES_DEPTH];
    logic [LEVEL_W-1:0]  shadow_level [SERIES_DEPTH];
    bit                  shadow_peak  [SERIES_DEPTH];
    bit                  shadow_mark  [SERIES_DEPTH];
    int                  shadow_count = 0;
    logic [WINDOW_W-1:0] shadow_window = WINDOW_RESET;

    result_t             expected_picks [$];
    step_row_t           directed_rows  [$];

    int  send_idle_pct   = 0;
    int  recv_idle_pct   = 0;
    bit  pressure_go     = 1'b0;
    logic hold_active    = 1'b0;
    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  commands_sent   = 0;
    int  window_writes   = 0;
    int  fills_done      = 0;
    int  cycle_count     = 0;

    windowed_peak_reselect_top #(
        .SERIES_DEPTH(SERIES_DEPTH)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .window_length_we   (window_length_we),
        .window_length_data (window_length_data),
        .item_valid         (item_valid),
        .item_ready         (item_ready),
        .command            (command),
        .sample_time        (sample_time),
        .glucose_level      (glucose_level),
        .peak_flag          (peak_flag),
        .sample_index       (sample_index),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .chosen_index       (chosen_index),
        .mark_value         (mark_value),
        .status             (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, expected_picks.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // adds one row at the end of the directed table
    function automatic void add_row(input step_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // applies one accepted command to the shadow state; returns 1 when it yields a result
    function automatic bit predict_pick(input cmd_t op, input logic [TIME_W-1:0] stamp,
                                        input logic [LEVEL_W-1:0] level, input logic peak,
                                        input logic [INDEX_W-1:0] index, output result_t res);
        logic [TIME_W:0]    lo;
        logic [TIME_W:0]    hi;
        bit                 found;
        int                 best;
        logic [LEVEL_W-1:0] best_level;
        int                 pick;
        res = '0;
        case (op)
            CMD_START:
            begin
                shadow_count = 0;
                foreach (shadow_mark[k]) shadow_mark[k] = 1'b0;
                return 1'b0;
            end
            CMD_APPEND:
            begin
                // a full store drops the sample
                if (shadow_count < SERIES_DEPTH)
                begin
                    shadow_time[shadow_count]  = stamp;
                    shadow_level[shadow_count] = level;
                    shadow_peak[shadow_count]  = peak;
                    shadow_count++;
                end
                return 1'b0;
            end
            default:
            begin
                if (int'(index) >= shadow_count)
                begin
                    res.status = 1'b1;
                    return 1'b1;
                end
                if (op == CMD_READ)
                begin
                    res.mark_value = shadow_mark[index];
                    return 1'b1;
                end
                // window end carries into bit 32 instead of wrapping
                lo = {1'b0, shadow_time[index]};
                hi = lo + {16'd0, shadow_window};
                found = 1'b0;
                best = 0;
                best_level = '0;
                for (int j = 0; j < shadow_count; j++)
                begin
                    if (shadow_peak[j] && {1'b0, shadow_time[j]} >= lo
                        && {1'b0, shadow_time[j]} <= hi)
                    begin
                        if (!found || shadow_level[j] > best_level)
                        begin
                            found = 1'b1;
                            best = j;
                            best_level = shadow_level[j];
                        end
                    end
                end
                // anchor takes over only when strictly higher
                pick = (!found || shadow_level[index] > best_level) ? int'(index) : best;
                shadow_mark[pick] = 1'b1;
                res.chosen_index = INDEX_W'(pick);
                res.mark_value = 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    // offers one command, waits for the transfer, then predicts at the accepting edge
    task automatic send_cmd(input cmd_t op, input logic [TIME_W-1:0] stamp,
                            input logic [LEVEL_W-1:0] level, input logic peak,
                            input logic [INDEX_W-1:0] index, input bit typed,
                            input result_t typed_res);
        result_t res;
        bit      has_res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        command       <= op;
        sample_time   <= stamp;
        glucose_level <= level;
        peak_flag     <= peak;
        sample_index  <= index;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        has_res = predict_pick(op, stamp, level, peak, index, res);
        if (has_res) expected_picks.insert(expected_picks.size(), typed ? typed_res : res);
        commands_sent++;
    endtask

    // window writes only once the block has drained
    task automatic write_window(input logic [WINDOW_W-1:0] value);
        item_valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        window_length_we   <= 1'b1;
        window_length_data <= value;
        @(posedge clk);
        window_length_we <= 1'b0;
        shadow_window = value;
        window_writes++;
    endtask

    // anchor or read index: mostly a loaded sample, sometimes anything the field allows
    function automatic logic [INDEX_W-1:0] pick_index(input bit stray);
        if (stray || shadow_count == 0) return INDEX_W'($urandom);
        return INDEX_W'($urandom_range(0, shadow_count - 1));
    endfunction

    // start, a run of appends with clustered times, then evaluates and reads mixed with more appends
    task automatic random_series(input bit fill_up);
        int                 n;
        int                 m;
        int                 r;
        int                 step_max;
        int                 level_lo;
        int                 level_hi;
        int                 peak_pct;
        logic [TIME_W-1:0]  stamp;
        logic [LEVEL_W-1:0] level;
        send_cmd(CMD_START, $urandom, LEVEL_W'($urandom), 1'($urandom), INDEX_W'($urandom),
                 1'b0, '0);
        r = $urandom_range(99);
        if (fill_up)      n = SERIES_DEPTH + $urandom_range(1, 4);
        else if (r < 5)   n = 0;
        else if (r < 85)  n = $urandom_range(1, 16);
        else              n = $urandom_range(17, 48);
        case ($urandom_range(3))
            0:       stamp = $urandom;
            1:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 50000);
            2:       stamp = $urandom_range(0, 1000);
            default: stamp = $urandom;
        endcase
        case ($urandom_range(4))
            0:       step_max = 0;
            1:       step_max = 30;
            2:       step_max = 600;
            3:       step_max = 3600;
            default: step_max = 40000;
        endcase
        // narrow level range makes ties common
        if ($urandom_range(1))
        begin
            level_lo = $urandom_range(0, 1019);
            level_hi = level_lo + 4;
        end
        else
        begin
            level_lo = 0;
            level_hi = 1023;
        end
        peak_pct = $urandom_range(10, 90);
        for (int i = 0; i < n; i++)
        begin
            level = LEVEL_W'($urandom_range(level_lo, level_hi));
            send_cmd(CMD_APPEND, stamp, level, $urandom_range(99) < peak_pct,
                     INDEX_W'($urandom), 1'b0, '0);
            stamp = stamp + TIME_W'($urandom_range(0, step_max));
        end
        m = fill_up ? 24 : $urandom_range(4, 16);
        for (int j = 0; j < m; j++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_cmd(CMD_EVAL, $urandom, LEVEL_W'($urandom), 1'($urandom),
                         pick_index(1'b0), 1'b0, '0);
            else if (r < 85)
                send_cmd(CMD_READ, $urandom, LEVEL_W'($urandom), 1'($urandom),
                         pick_index(1'b0), 1'b0, '0);
            else if (r < 95)
                send_cmd(CMD_APPEND, stamp + TIME_W'($urandom_range(0, step_max)),
                         LEVEL_W'($urandom_range(level_lo, level_hi)), 1'($urandom),
                         INDEX_W'($urandom), 1'b0, '0);
            else
                send_cmd(r[0] ? CMD_EVAL : CMD_READ, $urandom, LEVEL_W'($urandom),
                         1'($urandom), pick_index(1'b1), 1'b0, '0);
        end
        if (fill_up) fills_done++;
    endtask

    // one long receiver hold-off so results back up and the input stalls
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // result side: compare each transfer against the oldest expectation, then redraw ready
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %0d/%0d/%0d",
                         $time, chosen_index, mark_value, status);
                mismatch_count++;
            end
            else
            begin
                exp_res = expected_picks.pop_front();
                check_field("chosen_index", exp_res.chosen_index, chosen_index);
                check_field("mark_value", exp_res.mark_value, mark_value);
                check_field("status", exp_res.status, status);
                results_checked++;
            end
        end
        result_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        logic [WINDOW_W-1:0] phase_window [6];

        // directed table, run at the reset window of 7200
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd0,   1'b1, SKIP_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd0,   1'b1, SKIP_RES});
        add_row('{CMD_APPEND, 32'd0,         10'd0,    1'b0, 9'd0,   1'b0, CLEAR_RES});
        // flagged peak exactly at the window end, another one second past it
        add_row('{CMD_APPEND, 32'd7200,      10'd1023, 1'b1, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_APPEND, 32'd7201,      10'd1023, 1'b1, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd1,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd3,   1'b1, SKIP_RES});
        // near the top of time, window end runs past 2^32 - 1
        add_row('{CMD_APPEND, 32'hFFFF_FFF0, 10'd500,  1'b1, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_APPEND, 32'hFFFF_FFFF, 10'd500,  1'b1, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_APPEND, 32'hFFFF_FFFF, 10'd501,  1'b0, 9'd0,   1'b0, CLEAR_RES});
        // anchor strictly higher, anchor equal, tie on level
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd5,   1'b0, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd4,   1'b0, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd3,   1'b0, CLEAR_RES});
        // no flagged sample in the window, anchor marks itself
        add_row('{CMD_APPEND, 32'd20000,     10'd200,  1'b0, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd6,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd6,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd511, 1'b1, SKIP_RES});
        // start drops the series and the marks
        add_row('{CMD_START,  32'hFFFF_FFFF, 10'd1023, 1'b1, 9'd511, 1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd1,   1'b1, SKIP_RES});
        add_row('{CMD_APPEND, 32'd5,         10'd7,    1'b1, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd0,   1'b1, CLEAR_RES});
        add_row('{CMD_EVAL,   32'd0,         10'd0,    1'b0, 9'd0,   1'b0, CLEAR_RES});
        add_row('{CMD_READ,   32'd0,         10'd0,    1'b0, 9'd0,   1'b0, CLEAR_RES});

        // extremes of the register, 86400, a random one up to 86400, 1, then back to reset
        phase_window[0] = 17'd0;
        phase_window[1] = 17'h1FFFF;
        phase_window[2] = 17'd86400;
        phase_window[3] = WINDOW_W'($urandom_range(0, 86400));
        phase_window[4] = 17'd1;
        phase_window[5] = 17'd7200;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct <= 51;
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].stamp, directed_rows[i].level,
                     directed_rows[i].peak, directed_rows[i].index, directed_rows[i].typed,
                     directed_rows[i].res);

        for (int p = 0; p < 6; p++)
        begin
            int phase_start;
            write_window(phase_window[p]);
            // receiver slow first, then sender slow, then neither stalls
            if (p < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct <= 51;
            end
            else if (p < 4)
            begin
                send_idle_pct = 51;
                recv_idle_pct <= 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (p == 2) pressure_go = 1'b1;
            phase_start = commands_sent;
            while (commands_sent - phase_start < PHASE_ITEMS) random_series(1'b0);
            if (p == 5) random_series(1'b1);
        end

        // drain, then give the last appends time to settle
        item_valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d commands across %0d window settings, %0d results compared",
                 commands_sent, window_writes, results_checked);
        $display("store filled past capacity %0d time(s), one receiver hold-off of %0d cycles",
                 fills_done, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
